>>> rtl/afr_pkg.sv
// Shared types, constants and decode helpers for the ADC frame ring receiver.
// No dependencies; every other rtl file takes its names from here by scope.
`default_nettype none

package afr_pkg;

	localparam int RING_DEPTH_DEF     = 32;
	localparam int DISCARD_FRAMES_DEF = 2;

	localparam int DISCARD_W = 2;
	localparam int CH_W      = 24;
	localparam int SAMPLE_W  = 25;
	localparam int CNT_W     = 32;
	localparam int NUM_CH    = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

	// Status word bit positions (24-bit raw word)
	localparam int ST_RESET_BIT  = 18;
	localparam int ST_CRCERR_BIT = 20;
	localparam int ST_REGMAP_BIT = 21;

	typedef enum logic [1:0] {
		CMD_CAPTURE = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESUME  = 2'd2,
		CMD_PAUSE   = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		OUT_STORED    = 3'd0,
		OUT_DROPPED   = 3'd1,
		OUT_IGNORED   = 3'd2,
		OUT_FRAME     = 3'd3,
		OUT_DISCARDED = 3'd4,
		OUT_EMPTY     = 3'd5,
		OUT_MODE      = 3'd6
	} outcome_e_t;

	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] raw;
		logic [CH_W-1:0]             status;
	} frame_t;

	typedef struct packed {
		cmd_e_t cmd;
		frame_t frame;
	} item_t;

	typedef struct packed {
		outcome_e_t                      outcome;
		logic [CH_W-1:0]                 status;
		logic [NUM_CH-1:0][SAMPLE_W-1:0] samples;
		logic                            reset_seen;
		logic                            health_error;
		logic [CNT_W-1:0]                event_count;
		logic [CNT_W-1:0]                drop_count;
		logic [CNT_W-1:0]                error_count;
		logic [CNT_W-1:0]                read_count;
	} result_t;

	// Sign-extend a raw channel word and negate it when asked.
	function automatic logic [SAMPLE_W-1:0] decode_channel(input logic [CH_W-1:0] raw,
	                                                        input logic neg);
		logic [SAMPLE_W-1:0] ext;
		ext = {raw[CH_W-1], raw};
		return neg ? (~ext + SAMPLE_W'(1)) : ext;
	endfunction

endpackage

`default_nettype wire

>>> rtl/afr_front.sv
// Front end: accepts stream transactions, classifies the command and queues them.
// Depends on afr_pkg.
`default_nettype none

module afr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [119:0]        s_tdata,
	input  wire logic [1:0]          s_tuser,
	output logic                     q_valid,
	output afr_pkg::item_t           q_item,
	input  wire logic                q_pop
);

	afr_pkg::item_t                  entry_q [afr_pkg::QUEUE_DEPTH];
	logic [afr_pkg::QP_W-1:0]        head_q;
	logic [afr_pkg::QP_W-1:0]        tail_q;
	logic [afr_pkg::QC_W-1:0]        fill_q;
	logic                            push;
	afr_pkg::item_t                  item_in;

	assign s_tready = (fill_q != afr_pkg::QC_W'(afr_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (fill_q != '0);
	assign q_item   = entry_q[head_q];

	// Classify the command; frame words are kept only for captures.
	always_comb begin
		item_in.cmd   = afr_pkg::cmd_e_t'(s_tuser);
		item_in.frame = s_tdata;
		unique case (item_in.cmd)
			afr_pkg::CMD_CAPTURE: item_in.frame = s_tdata;
			afr_pkg::CMD_READ, afr_pkg::CMD_RESUME, afr_pkg::CMD_PAUSE: item_in.frame = '0;
			default: item_in.frame = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == afr_pkg::QP_W'(afr_pkg::QUEUE_DEPTH - 1)) ? '0
				          : tail_q + 1'b1;
			end
			if (q_pop) begin
				head_q <= (head_q == afr_pkg::QP_W'(afr_pkg::QUEUE_DEPTH - 1)) ? '0
				          : head_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/afr_back.sv
// Back end: ring of frame slots, counters, decode and the output register.
// Depends on afr_pkg.
`default_nettype none

module afr_back #(
	parameter int RING_DEPTH     = afr_pkg::RING_DEPTH_DEF,
	parameter int DISCARD_FRAMES = afr_pkg::DISCARD_FRAMES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                polarity_mask_wen,
	input  wire logic [3:0]          polarity_mask_wdata,
	input  wire logic                q_valid,
	input  afr_pkg::item_t           q_item,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output afr_pkg::result_t         m_result
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W = $clog2(RING_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_e_t;

	state_e_t                        state_q, state_d;
	logic [PTR_W-1:0]                wp_q, wp_d, rp_q, rp_d;
	logic [FILL_W-1:0]               fill_q, fill_d;
	logic [afr_pkg::DISCARD_W-1:0]   discard_q, discard_d;
	logic                            streaming_q, streaming_d;
	logic                            reset_flag_q, reset_flag_d;
	logic [afr_pkg::CNT_W-1:0]       events_q, events_d, drops_q, drops_d;
	logic [afr_pkg::CNT_W-1:0]       errors_q, errors_d, reads_q, reads_d;
	logic [3:0]                      polarity_q;
	logic                            out_valid_q;
	afr_pkg::result_t                res_q, res_d;
	logic                            out_free, out_load;
	logic                            mem_we, mem_re;
	logic                            ring_full, ring_empty, err;
	afr_pkg::frame_t                 frame_mem [RING_DEPTH];
	afr_pkg::frame_t                 rd_data_q;

	assign out_free   = !out_valid_q || m_tready;
	assign ring_full  = (fill_q == FILL_W'(RING_DEPTH));
	assign ring_empty = (fill_q == '0);
	assign err        = rd_data_q.status[afr_pkg::ST_REGMAP_BIT]
	                    | rd_data_q.status[afr_pkg::ST_CRCERR_BIT];
	assign m_tvalid   = out_valid_q;
	assign m_result   = res_q;

	always_comb begin
		state_d      = state_q;
		wp_d         = wp_q;
		rp_d         = rp_q;
		fill_d       = fill_q;
		discard_d    = discard_q;
		streaming_d  = streaming_q;
		reset_flag_d = reset_flag_q;
		events_d     = events_q;
		drops_d      = drops_q;
		errors_d     = errors_q;
		reads_d      = reads_q;
		res_d        = '0;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		q_pop        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					unique case (q_item.cmd)
						afr_pkg::CMD_CAPTURE: begin
							out_load = 1'b1;
							if (!streaming_q) begin
								res_d.outcome = afr_pkg::OUT_IGNORED;
							end else if (ring_full) begin
								events_d      = events_q + 1'b1;
								drops_d       = drops_q + 1'b1;
								res_d.outcome = afr_pkg::OUT_DROPPED;
							end else begin
								events_d      = events_q + 1'b1;
								mem_we        = 1'b1;
								wp_d          = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0
								                : wp_q + 1'b1;
								fill_d        = fill_q + 1'b1;
								res_d.outcome = afr_pkg::OUT_STORED;
							end
						end
						afr_pkg::CMD_READ: begin
							if (ring_empty) begin
								out_load      = 1'b1;
								res_d.outcome = afr_pkg::OUT_EMPTY;
							end else begin
								rp_d   = (rp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
								fill_d = fill_q - 1'b1;
								if (discard_q != '0) begin
									discard_d     = discard_q - 1'b1;
									out_load      = 1'b1;
									res_d.outcome = afr_pkg::OUT_DISCARDED;
								end else begin
									mem_re  = 1'b1;
									reads_d = reads_q + 1'b1;
									state_d = ST_FETCH;
								end
							end
						end
						afr_pkg::CMD_RESUME: begin
							discard_d     = afr_pkg::DISCARD_W'(DISCARD_FRAMES);
							streaming_d   = 1'b1;
							out_load      = 1'b1;
							res_d.outcome = afr_pkg::OUT_MODE;
						end
						afr_pkg::CMD_PAUSE: begin
							streaming_d   = 1'b0;
							out_load      = 1'b1;
							res_d.outcome = afr_pkg::OUT_MODE;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				if (out_free) begin
					out_load           = 1'b1;
					state_d            = ST_IDLE;
					res_d.outcome      = afr_pkg::OUT_FRAME;
					res_d.status       = rd_data_q.status;
					res_d.health_error = err;
					for (int i = 0; i < afr_pkg::NUM_CH; i++) begin
						res_d.samples[i] = afr_pkg::decode_channel(rd_data_q.raw[i],
						                                           polarity_q[i]);
					end
					if (rd_data_q.status[afr_pkg::ST_RESET_BIT]) begin
						reset_flag_d = 1'b1;
					end
					if (err) begin
						errors_d = errors_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase

		res_d.reset_seen  = reset_flag_d;
		res_d.event_count = events_d;
		res_d.drop_count  = drops_d;
		res_d.error_count = errors_d;
		res_d.read_count  = reads_d;
	end

	// Frame store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[wp_q] <= q_item.frame;
		end
		if (mem_re) begin
			rd_data_q <= frame_mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			fill_q       <= '0;
			discard_q    <= '0;
			streaming_q  <= 1'b0;
			reset_flag_q <= 1'b0;
			events_q     <= '0;
			drops_q      <= '0;
			errors_q     <= '0;
			reads_q      <= '0;
			polarity_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			wp_q         <= wp_d;
			rp_q         <= rp_d;
			fill_q       <= fill_d;
			discard_q    <= discard_d;
			streaming_q  <= streaming_d;
			reset_flag_q <= reset_flag_d;
			events_q     <= events_d;
			drops_q      <= drops_d;
			errors_q     <= errors_d;
			reads_q      <= reads_d;
			if (polarity_mask_wen) begin
				polarity_q <= polarity_mask_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("ring fill count exceeds depth");

	a_no_pop_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> !q_pop)
		else $error("queue popped while a frame fetch is pending");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !ring_full)
		else $error("frame written into a full ring");

	a_read_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> state_q == ST_FETCH && $past(!ring_empty))
		else $error("frame fetch issued on an empty ring");

	a_frame_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_d.outcome == afr_pkg::OUT_FRAME |-> state_q == ST_FETCH)
		else $error("frame result loaded outside the fetch state");

endmodule

`default_nettype wire

>>> rtl/adc_frame_ring_receiver.sv
// Top level of the ADC frame ring receiver: front queue plus ring back end.
// Depends on afr_pkg, afr_front and afr_back.
//
//  channel   dir  handshake           tuser            tdata
//  s_*       in   s_tvalid/s_tready   command [1:0]    status_in, raw_ch0..raw_ch3
//  m_*       out  m_tvalid/m_tready   outcome [2:0]    status_out, sample0..3, flags, counters
//  cfg       in   polarity_mask_wen   -                polarity_mask_wdata [3:0]
//
// Capture, resume, pause, empty and discarded reads finish in the back end's idle state;
// a delivered frame also passes the fetch state, as the frame store's read port is
// registered. A two-entry queue decouples input acceptance from the back end, and the
// output register takes the next result as soon as the current one is taken. Reset is
// asynchronous and active low; the frame store needs no clearing pass, since a fill
// count tracks the held frames. A stalled output stalls the input once the queue is full.
`default_nettype none

module adc_frame_ring_receiver #(
	parameter int RING_DEPTH     = afr_pkg::RING_DEPTH_DEF,
	parameter int DISCARD_FRAMES = afr_pkg::DISCARD_FRAMES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          polarity_mask_wen,
	input  wire logic [3:0]    polarity_mask_wdata,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// [23:0] status_in, [47:24] raw_ch0, [71:48] raw_ch1, [95:72] raw_ch2, [119:96] raw_ch3
	input  wire logic [119:0]  s_tdata,
	// [1:0] command
	input  wire logic [1:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// [23:0] status_out, [48:24] sample0, [73:49] sample1, [98:74] sample2,
	// [123:99] sample3, [124] reset_seen, [125] health_error, [157:126] event_count,
	// [189:158] drop_count, [221:190] error_count, [253:222] read_count, [255:254] zero
	output logic [255:0]       m_tdata,
	// [2:0] outcome
	output logic [2:0]         m_tuser
);

	logic             q_valid;
	logic             q_pop;
	afr_pkg::item_t   q_item;
	afr_pkg::result_t res;

	// Accept and classify transactions, hold them in the short queue.
	afr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Advance the ring, count events and decode delivered frames.
	afr_back #(
		.RING_DEPTH     (RING_DEPTH),
		.DISCARD_FRAMES (DISCARD_FRAMES)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.polarity_mask_wen   (polarity_mask_wen),
		.polarity_mask_wdata (polarity_mask_wdata),
		.q_valid             (q_valid),
		.q_item              (q_item),
		.q_pop               (q_pop),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_result            (res)
	);

	// Pack the result fields, first field in the lowest bits.
	assign m_tdata = {2'b00, res.read_count, res.error_count, res.drop_count,
	                  res.event_count, res.health_error, res.reset_seen,
	                  res.samples[3], res.samples[2], res.samples[1], res.samples[0],
	                  res.status};
	assign m_tuser = res.outcome;

endmodule

`default_nettype wire
